// ----- sv/cpt_pkg.sv -----
// Types, constants and helper functions shared by the Clarke/Park transform.
`default_nettype none

package cpt_pkg;

  // Fixed field widths of the item formats.
  localparam int VALUE_BITS = 16;
  localparam int ANGLE_BITS = 16;
  localparam int OP_BITS = 2;

  // Default sine table resolution (entries per quarter turn).
  localparam int unsigned SINE_TABLE_DEPTH = 256;

  // Fixed point: coefficients and sine entries carry 24 fraction bits.
  localparam int COEF_FRAC = 24;
  localparam int COEF_BITS = COEF_FRAC + 1;          // signed coefficient
  localparam int SIN_BITS = COEF_FRAC + 1;           // unsigned 0 .. 2^24
  localparam int TRIG_BITS = SIN_BITS + 1;           // signed sine / cosine
  localparam int MIX_BITS = VALUE_BITS + 2;          // Clarke result before clamp
  localparam int ROT_BITS = VALUE_BITS + 4;          // rotation result before clamp
  localparam int IP_BITS = COEF_BITS + ROT_BITS;     // inverse Clarke product
  localparam int SAT_BITS = VALUE_BITS + 8;          // clamp input width

  // sqrt(2/3) and 1/sqrt(2), rounded to 24 fraction bits.
  localparam logic signed [COEF_BITS-1:0] S23_COEF = 25'sd13698540;
  localparam logic signed [COEF_BITS-1:0] ISQ2_COEF = 25'sd11863283;

  // pi/2 in Q.30, used to build the sine table.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Source frame codes.
  localparam logic [OP_BITS-1:0] OP_ABC = 2'd0;
  localparam logic [OP_BITS-1:0] OP_AB = 2'd1;
  localparam logic [OP_BITS-1:0] OP_DQ = 2'd2;

  localparam logic signed [SAT_BITS-1:0] SAT_HI = SAT_BITS'((1 << (VALUE_BITS - 1)) - 1);
  localparam logic signed [SAT_BITS-1:0] SAT_LO = -SAT_HI - 1;

  typedef logic [OP_BITS-1:0] op_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [TRIG_BITS-1:0] trig_t;
  typedef logic signed [MIX_BITS-1:0] mix_t;
  typedef logic signed [ROT_BITS-1:0] rot_t;
  typedef logic signed [IP_BITS-1:0] iprod_t;

  typedef struct packed {
    op_t operation;
    value_t in_first;
    value_t in_second;
    value_t in_third;
    logic [ANGLE_BITS-1:0] angle;
  } in_item_t;

  typedef struct packed {
    value_t phase_a;
    value_t phase_b;
    value_t phase_c;
    value_t alpha_axis;
    value_t beta_axis;
    value_t direct_axis;
    value_t quadrature_axis;
    logic clipped;
  } out_item_t;

  // Per-stage load strobes, first stage to last.
  typedef struct packed {
    logic lookup;
    logic scale;
    logic mix;
    logic mult;
    logic rot;
    logic inv;
    logic out;
  } stage_ld_t;

  typedef struct packed {
    logic clip;
    value_t value;
  } sat_t;

  function automatic sat_t saturate(input logic signed [SAT_BITS-1:0] v);
    sat_t r;
    r.clip = 1'b0;
    r.value = v[VALUE_BITS-1:0];
    if (v > SAT_HI) begin
      r.clip = 1'b1;
      r.value = SAT_HI[VALUE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r.clip = 1'b1;
      r.value = SAT_LO[VALUE_BITS-1:0];
    end
    return r;
  endfunction

  // sin(x) for x in Q.30, Taylor series to x^15, rounded to 24 fraction bits.
  function automatic logic [SIN_BITS-1:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] e;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - $signed(term);
    if (sum < 64'sd0) sum = 64'sd0;
    e = (sum + 64'sd32) >>> 6;
    if (e > (64'sd1 <<< COEF_FRAC)) e = 64'sd1 <<< COEF_FRAC;
    return e[SIN_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/cpt_sincos.sv -----
// Sine/cosine lookup: quarter-wave table read, then quadrant sign and mirror.
`default_nettype none

module cpt_sincos #(
  parameter int unsigned SINE_TABLE_DEPTH = cpt_pkg::SINE_TABLE_DEPTH
) (
  input  logic                            clk,
  input  cpt_pkg::stage_ld_t              ld,
  input  logic [cpt_pkg::ANGLE_BITS-1:0]  angle,
  output cpt_pkg::trig_t                  sine,
  output cpt_pkg::trig_t                  cosine
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int RW = cpt_pkg::ANGLE_BITS - 2;
  localparam int SW = RW + AW;

  localparam logic [1:0] QUAD_RISE = 2'd0;
  localparam logic [1:0] QUAD_TOP = 2'd1;
  localparam logic [1:0] QUAD_FALL = 2'd2;

  logic [cpt_pkg::SIN_BITS-1:0] rom [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] ENTRY_X =
      (cpt_pkg::HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    localparam logic [cpt_pkg::SIN_BITS-1:0] ENTRY = cpt_pkg::sine_entry(ENTRY_X);
    assign rom[k] = ENTRY;
  end

  logic [SW-1:0] scaled;
  logic [AW-1:0] lo_idx;
  logic [AW-1:0] hi_idx;

  // Nearest table point below the angle within the quadrant.
  assign scaled = SW'(angle[RW-1:0]) * SW'(SINE_TABLE_DEPTH);
  assign lo_idx = scaled[RW +: AW];
  assign hi_idx = AW'(SINE_TABLE_DEPTH) - lo_idx;

  logic [1:0] quad;
  logic [cpt_pkg::SIN_BITS-1:0] lo;
  logic [cpt_pkg::SIN_BITS-1:0] hi;
  cpt_pkg::trig_t lo_pos;
  cpt_pkg::trig_t hi_pos;

  always_ff @(posedge clk) begin
    if (ld.lookup) begin
      quad <= angle[cpt_pkg::ANGLE_BITS-1 -: 2];
      lo <= rom[lo_idx];
      hi <= rom[hi_idx];
    end
  end

  assign lo_pos = $signed({1'b0, lo});
  assign hi_pos = $signed({1'b0, hi});

  always_ff @(posedge clk) begin
    if (ld.scale) begin
      case (quad)
        QUAD_RISE: begin
          sine <= lo_pos;
          cosine <= hi_pos;
        end
        QUAD_TOP: begin
          sine <= hi_pos;
          cosine <= -lo_pos;
        end
        QUAD_FALL: begin
          sine <= -lo_pos;
          cosine <= -hi_pos;
        end
        default: begin
          sine <= -hi_pos;
          cosine <= lo_pos;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/cpt_clarke.sv -----
// Forward Clarke: products, then rounding and selection of the rotation input.
`default_nettype none

module cpt_clarke (
  input  logic               clk,
  input  cpt_pkg::stage_ld_t ld,
  input  cpt_pkg::value_t    x1,
  input  cpt_pkg::value_t    y1,
  input  cpt_pkg::value_t    z1,
  input  cpt_pkg::op_t       op2,
  input  cpt_pkg::value_t    x2,
  input  cpt_pkg::value_t    y2,
  output cpt_pkg::mix_t      u,
  output cpt_pkg::mix_t      v
);

  localparam int DA_BITS = cpt_pkg::VALUE_BITS + 3;
  localparam int DB_BITS = cpt_pkg::VALUE_BITS + 1;
  localparam int PA_BITS = cpt_pkg::COEF_BITS + DA_BITS;
  localparam int PB_BITS = cpt_pkg::COEF_BITS + DB_BITS;
  localparam logic signed [PA_BITS-1:0] PA_HALF = PA_BITS'(1) << cpt_pkg::COEF_FRAC;
  localparam logic signed [PB_BITS-1:0] PB_HALF = PB_BITS'(1) << (cpt_pkg::COEF_FRAC - 1);

  logic signed [DA_BITS-1:0] diff_a;
  logic signed [DB_BITS-1:0] diff_b;
  logic signed [PA_BITS-1:0] prod_a;
  logic signed [PB_BITS-1:0] prod_b;
  logic signed [PA_BITS-1:0] sum_a;
  logic signed [PB_BITS-1:0] sum_b;

  assign diff_a = (DA_BITS'(x1) <<< 1) - DA_BITS'(y1) - DA_BITS'(z1);
  assign diff_b = DB_BITS'(y1) - DB_BITS'(z1);

  always_ff @(posedge clk) begin
    if (ld.scale) begin
      prod_a <= cpt_pkg::S23_COEF * diff_a;
      prod_b <= cpt_pkg::ISQ2_COEF * diff_b;
    end
  end

  assign sum_a = prod_a + PA_HALF;
  assign sum_b = prod_b + PB_HALF;

  always_ff @(posedge clk) begin
    if (ld.mix) begin
      if (op2 == cpt_pkg::OP_ABC) begin
        u <= cpt_pkg::MIX_BITS'(sum_a >>> (cpt_pkg::COEF_FRAC + 1));
        v <= cpt_pkg::MIX_BITS'(sum_b >>> cpt_pkg::COEF_FRAC);
      end else begin
        u <= cpt_pkg::MIX_BITS'(x2);
        v <= cpt_pkg::MIX_BITS'(y2);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/cpt_rotate.sv -----
// Park rotation: direction select, four products, then sums with rounding.
`default_nettype none

module cpt_rotate (
  input  logic               clk,
  input  cpt_pkg::stage_ld_t ld,
  input  cpt_pkg::op_t       op2,
  input  cpt_pkg::trig_t     sine,
  input  cpt_pkg::trig_t     cosine,
  input  cpt_pkg::mix_t      u,
  input  cpt_pkg::mix_t      v,
  output cpt_pkg::rot_t      r1,
  output cpt_pkg::rot_t      r2
);

  localparam int RP_BITS = cpt_pkg::TRIG_BITS + cpt_pkg::MIX_BITS;
  localparam int RS_BITS = RP_BITS + 1;
  localparam logic signed [RS_BITS-1:0] HALF = RS_BITS'(1) << (cpt_pkg::COEF_FRAC - 1);

  cpt_pkg::trig_t sn;
  cpt_pkg::trig_t cs;
  logic signed [RP_BITS-1:0] p_cu;
  logic signed [RP_BITS-1:0] p_sv;
  logic signed [RP_BITS-1:0] p_cv;
  logic signed [RP_BITS-1:0] p_su;
  logic signed [RS_BITS-1:0] sum1;
  logic signed [RS_BITS-1:0] sum2;

  // From d/q the rotation runs backwards: negate the sine.
  always_ff @(posedge clk) begin
    if (ld.mix) begin
      cs <= cosine;
      sn <= (op2 == cpt_pkg::OP_DQ) ? -sine : sine;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.mult) begin
      p_cu <= cs * u;
      p_sv <= sn * v;
      p_cv <= cs * v;
      p_su <= sn * u;
    end
  end

  assign sum1 = RS_BITS'(p_cu) + RS_BITS'(p_sv) + HALF;
  assign sum2 = RS_BITS'(p_cv) - RS_BITS'(p_su) + HALF;

  always_ff @(posedge clk) begin
    if (ld.rot) begin
      r1 <= cpt_pkg::ROT_BITS'(sum1 >>> cpt_pkg::COEF_FRAC);
      r2 <= cpt_pkg::ROT_BITS'(sum2 >>> cpt_pkg::COEF_FRAC);
    end
  end

endmodule

`default_nettype wire

// ----- sv/cpt_iclarke.sv -----
// Inverse Clarke products on alpha/beta taken from the input or the rotation.
`default_nettype none

module cpt_iclarke (
  input  logic               clk,
  input  cpt_pkg::stage_ld_t ld,
  input  cpt_pkg::op_t       op5,
  input  cpt_pkg::mix_t      u5,
  input  cpt_pkg::mix_t      v5,
  input  cpt_pkg::rot_t      r1,
  input  cpt_pkg::rot_t      r2,
  output cpt_pkg::iprod_t    prod_a,
  output cpt_pkg::iprod_t    prod_b
);

  cpt_pkg::rot_t ca;
  cpt_pkg::rot_t cb;

  assign ca = (op5 == cpt_pkg::OP_DQ) ? r1 : cpt_pkg::ROT_BITS'(u5);
  assign cb = (op5 == cpt_pkg::OP_DQ) ? r2 : cpt_pkg::ROT_BITS'(v5);

  always_ff @(posedge clk) begin
    if (ld.inv) begin
      prod_a <= cpt_pkg::S23_COEF * ca;
      prod_b <= cpt_pkg::ISQ2_COEF * cb;
    end
  end

endmodule

`default_nettype wire

// ----- sv/clarke_park_transform.sv -----
// Top level of the three-phase Clarke/Park transform pipeline.
`default_nettype none

// One item carries a set of vector-control quantities in one source frame
// (abc phases, alpha/beta or d/q, chosen by operation) plus a rotor angle;
// the result item gives all three frames, Q1.15, saturated, with clipped set
// when any computed field hit a rail. Source-frame fields come back as given.
// Clarke is the power-invariant form (sqrt(2/3) scale), Park a pure rotation
// with sine and cosine from a quarter-wave table of SINE_TABLE_DEPTH+1
// entries, nearest point below, no interpolation. Operation 3 returns zeros.
// Throughput: one item per clock while out_ready is high. An item
// passes through seven register stages (table read, sign fix / Clarke
// products, rounding, rotation products, rotation sums, inverse Clarke
// products, clamp and output register). Each stage has its own valid bit
// and takes a new item whenever it is empty or the next stage moves, so
// bubbles are squeezed out under backpressure and in_ready stays high while
// out_ready is high or the output register is empty. The sine table is read
// at two addresses per item (sine and its mirror for cosine); it is constant,
// so there is no start-up pass.

module clarke_park_transform #(
  parameter int unsigned SINE_TABLE_DEPTH = cpt_pkg::SINE_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cpt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cpt_pkg::out_item_t out_item
);

  localparam int STAGES = 7;
  localparam int CARRY = STAGES - 1;
  localparam int SUM_BITS = cpt_pkg::IP_BITS + 2;
  localparam logic signed [SUM_BITS-1:0] HALF_A = SUM_BITS'(1) << (cpt_pkg::COEF_FRAC - 1);
  localparam logic signed [SUM_BITS-1:0] HALF_B = SUM_BITS'(1) << cpt_pkg::COEF_FRAC;

  // Stage valids and ready chain.
  logic [STAGES:1] vld;
  logic [STAGES:1] rdy;
  logic [STAGES:1] ld;
  cpt_pkg::stage_ld_t ld_s;

  always_comb begin
    rdy[STAGES] = !vld[STAGES] || out_ready;
    for (int i = STAGES - 1; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign ld = rdy & {vld[STAGES-1:1], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (rdy & {vld[STAGES-1:1], in_valid}) | (~rdy & vld);
    end
  end

  assign in_ready = rdy[1];
  assign out_valid = vld[STAGES];

  assign ld_s.lookup = ld[1];
  assign ld_s.scale = ld[2];
  assign ld_s.mix = ld[3];
  assign ld_s.mult = ld[4];
  assign ld_s.rot = ld[5];
  assign ld_s.inv = ld[6];
  assign ld_s.out = ld[7];

  // Operation and raw inputs ride along for passthrough fields.
  cpt_pkg::op_t op_s [1:CARRY];
  cpt_pkg::value_t x_s [1:CARRY];
  cpt_pkg::value_t y_s [1:CARRY];
  cpt_pkg::value_t z_s [1:CARRY];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      op_s[1] <= in_item.operation;
      x_s[1] <= in_item.in_first;
      y_s[1] <= in_item.in_second;
      z_s[1] <= in_item.in_third;
    end
    for (int i = 2; i <= CARRY; i++) begin
      if (ld[i]) begin
        op_s[i] <= op_s[i-1];
        x_s[i] <= x_s[i-1];
        y_s[i] <= y_s[i-1];
        z_s[i] <= z_s[i-1];
      end
    end
  end

  cpt_pkg::trig_t sine;
  cpt_pkg::trig_t cosine;

  cpt_sincos #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sincos (
    .clk    (clk),
    .ld     (ld_s),
    .angle  (in_item.angle),
    .sine   (sine),
    .cosine (cosine)
  );

  cpt_pkg::mix_t u3;
  cpt_pkg::mix_t v3;

  cpt_clarke u_clarke (
    .clk (clk),
    .ld  (ld_s),
    .x1  (x_s[1]),
    .y1  (y_s[1]),
    .z1  (z_s[1]),
    .op2 (op_s[2]),
    .x2  (x_s[2]),
    .y2  (y_s[2]),
    .u   (u3),
    .v   (v3)
  );

  // Clarke output (or raw alpha/beta) kept for the clamp stage.
  cpt_pkg::mix_t u_s [4:CARRY];
  cpt_pkg::mix_t v_s [4:CARRY];

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      u_s[4] <= u3;
      v_s[4] <= v3;
    end
    for (int i = 5; i <= CARRY; i++) begin
      if (ld[i]) begin
        u_s[i] <= u_s[i-1];
        v_s[i] <= v_s[i-1];
      end
    end
  end

  cpt_pkg::rot_t r1;
  cpt_pkg::rot_t r2;

  cpt_rotate u_rotate (
    .clk    (clk),
    .ld     (ld_s),
    .op2    (op_s[2]),
    .sine   (sine),
    .cosine (cosine),
    .u      (u3),
    .v      (v3),
    .r1     (r1),
    .r2     (r2)
  );

  cpt_pkg::rot_t r1_s6;
  cpt_pkg::rot_t r2_s6;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      r1_s6 <= r1;
      r2_s6 <= r2;
    end
  end

  cpt_pkg::iprod_t prod_a;
  cpt_pkg::iprod_t prod_b;

  cpt_iclarke u_iclarke (
    .clk    (clk),
    .ld     (ld_s),
    .op5    (op_s[5]),
    .u5     (u_s[5]),
    .v5     (v_s[5]),
    .r1     (r1),
    .r2     (r2),
    .prod_a (prod_a),
    .prod_b (prod_b)
  );

  // Final stage: inverse Clarke sums, clamps, field selection.
  logic signed [SUM_BITS-1:0] sum_a;
  logic signed [SUM_BITS-1:0] sum_b;
  logic signed [SUM_BITS-1:0] sum_c;
  cpt_pkg::sat_t sat_a;
  cpt_pkg::sat_t sat_b;
  cpt_pkg::sat_t sat_c;
  cpt_pkg::sat_t sat_u;
  cpt_pkg::sat_t sat_v;
  cpt_pkg::sat_t sat_r1;
  cpt_pkg::sat_t sat_r2;
  logic inv_clip;
  logic rot_clip;
  cpt_pkg::out_item_t out_next;

  assign sum_a = SUM_BITS'(prod_a) + HALF_A;
  assign sum_b = -SUM_BITS'(prod_a) + (SUM_BITS'(prod_b) <<< 1) + HALF_B;
  assign sum_c = -SUM_BITS'(prod_a) - (SUM_BITS'(prod_b) <<< 1) + HALF_B;

  assign sat_a = cpt_pkg::saturate(cpt_pkg::SAT_BITS'(sum_a >>> cpt_pkg::COEF_FRAC));
  assign sat_b = cpt_pkg::saturate(cpt_pkg::SAT_BITS'(sum_b >>> (cpt_pkg::COEF_FRAC + 1)));
  assign sat_c = cpt_pkg::saturate(cpt_pkg::SAT_BITS'(sum_c >>> (cpt_pkg::COEF_FRAC + 1)));
  assign sat_u = cpt_pkg::saturate(cpt_pkg::SAT_BITS'(u_s[CARRY]));
  assign sat_v = cpt_pkg::saturate(cpt_pkg::SAT_BITS'(v_s[CARRY]));
  assign sat_r1 = cpt_pkg::saturate(cpt_pkg::SAT_BITS'(r1_s6));
  assign sat_r2 = cpt_pkg::saturate(cpt_pkg::SAT_BITS'(r2_s6));

  assign inv_clip = sat_a.clip | sat_b.clip | sat_c.clip;
  assign rot_clip = sat_r1.clip | sat_r2.clip;

  always_comb begin
    out_next = '0;
    case (op_s[CARRY])
      cpt_pkg::OP_ABC: begin
        out_next.phase_a = x_s[CARRY];
        out_next.phase_b = y_s[CARRY];
        out_next.phase_c = z_s[CARRY];
        out_next.alpha_axis = sat_u.value;
        out_next.beta_axis = sat_v.value;
        out_next.direct_axis = sat_r1.value;
        out_next.quadrature_axis = sat_r2.value;
        out_next.clipped = sat_u.clip | sat_v.clip | rot_clip;
      end
      cpt_pkg::OP_AB: begin
        out_next.phase_a = sat_a.value;
        out_next.phase_b = sat_b.value;
        out_next.phase_c = sat_c.value;
        out_next.alpha_axis = x_s[CARRY];
        out_next.beta_axis = y_s[CARRY];
        out_next.direct_axis = sat_r1.value;
        out_next.quadrature_axis = sat_r2.value;
        out_next.clipped = inv_clip | rot_clip;
      end
      cpt_pkg::OP_DQ: begin
        out_next.phase_a = sat_a.value;
        out_next.phase_b = sat_b.value;
        out_next.phase_c = sat_c.value;
        out_next.alpha_axis = sat_r1.value;
        out_next.beta_axis = sat_r2.value;
        out_next.direct_axis = x_s[CARRY];
        out_next.quadrature_axis = y_s[CARRY];
        out_next.clipped = inv_clip | rot_clip;
      end
      default: begin
        out_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_s.out) begin
      out_item <= out_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cpt_checker.sv -----
// Port-level checks for the Clarke/Park transform, bound to the top level.
`default_nettype none

module cpt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input cpt_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input cpt_pkg::out_item_t out_item
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // A free output register means every stage can move, so in_ready is high.
  a_ready_when_drain: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low while the output side can drain");

  // A waiting result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed or dropped");

  // Only an accepted item can fill an empty pipeline's first stage: with no
  // input taken and output empty, nothing can appear on the next edge unless
  // something was already in flight, which keeps in_ready high anyway.
  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && in_ready && $past(!out_valid) && $past(in_ready) && !in_valid
     && $past(!in_valid)) |-> ##0 in_ready)
    else $error("pipeline lost ready while idle");

endmodule

bind clarke_park_transform cpt_checker u_checker (.*);

`default_nettype wire

// ----- tb/clarke_park_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the Clarke/Park transform: predicts each result item and compares it.
module clarke_park_checker
  import cpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_item,
  output int         mismatch_count,
  output int         frames_pending
);

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  longint    sine_q24 [0:SINE_TABLE_DEPTH];
  longint    root_two_thirds;
  longint    inv_root_two;
  out_item_t expected_frames [$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Constant tables: Q.24 coefficients and a quarter-wave sine by Taylor series.
  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          entry;
    root_two_thirds = longint'((int_sqrt((64'd1 << 51) / 3) + 1) >> 1);
    inv_root_two = longint'((int_sqrt(64'd1 << 49) + 1) >> 1);
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (QUARTER_TURN_Q30 * k) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      entry = (acc + 32) >>> 6;
      if (entry > (longint'(1) <<< COEF_FRAC)) entry = longint'(1) <<< COEF_FRAC;
      sine_q24[k] = entry;
    end
  end

  // Round half up at the final shift.
  function automatic longint round_down(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic value_t clamp(longint v, inout bit hit);
    longint top_val;
    top_val = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
    if (v > top_val) begin
      hit = 1'b1;
      return value_t'(top_val);
    end
    if (v < -top_val - 1) begin
      hit = 1'b1;
      return value_t'(-top_val - 1);
    end
    return value_t'(v);
  endfunction

  function automatic out_item_t transform_frames(in_item_t it);
    out_item_t r;
    longint    x, y, z, sn, cs, lo, hi, ra, rb, rest, idx;
    logic [1:0] quad;
    bit        clip;
    r = '0;
    clip = 1'b0;
    x = it.in_first;
    y = it.in_second;
    z = it.in_third;
    quad = it.angle[ANGLE_BITS-1 -: 2];
    rest = it.angle[ANGLE_BITS-3:0];
    idx = (rest * SINE_TABLE_DEPTH) >>> (ANGLE_BITS - 2);
    if (idx > SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH;
    lo = sine_q24[idx];
    hi = sine_q24[SINE_TABLE_DEPTH - idx];
    case (quad)
      2'd0: begin sn = lo;  cs = hi;  end
      2'd1: begin sn = hi;  cs = -lo; end
      2'd2: begin sn = -lo; cs = -hi; end
      default: begin sn = -hi; cs = lo; end
    endcase
    case (it.operation)
      OP_ABC: begin
        ra = round_down(root_two_thirds * (2 * x - y - z), COEF_FRAC + 1);
        rb = round_down(inv_root_two * (y - z), COEF_FRAC);
        r.phase_a = it.in_first;
        r.phase_b = it.in_second;
        r.phase_c = it.in_third;
        r.direct_axis = clamp(round_down(cs * ra + sn * rb, COEF_FRAC), clip);
        r.quadrature_axis = clamp(round_down(cs * rb - sn * ra, COEF_FRAC), clip);
        r.alpha_axis = clamp(ra, clip);
        r.beta_axis = clamp(rb, clip);
      end
      OP_AB, OP_DQ: begin
        if (it.operation == OP_AB) begin
          ra = x;
          rb = y;
          r.alpha_axis = it.in_first;
          r.beta_axis = it.in_second;
          r.direct_axis = clamp(round_down(cs * x + sn * y, COEF_FRAC), clip);
          r.quadrature_axis = clamp(round_down(cs * y - sn * x, COEF_FRAC), clip);
        end else begin
          r.direct_axis = it.in_first;
          r.quadrature_axis = it.in_second;
          ra = round_down(cs * x - sn * y, COEF_FRAC);
          rb = round_down(sn * x + cs * y, COEF_FRAC);
          r.alpha_axis = clamp(ra, clip);
          r.beta_axis = clamp(rb, clip);
        end
        r.phase_a = clamp(round_down(root_two_thirds * ra, COEF_FRAC), clip);
        r.phase_b = clamp(round_down(-root_two_thirds * ra + 2 * inv_root_two * rb,
                                     COEF_FRAC + 1), clip);
        r.phase_c = clamp(round_down(-root_two_thirds * ra - 2 * inv_root_two * rb,
                                     COEF_FRAC + 1), clip);
      end
      default: ;  // undefined frame: all zero
    endcase
    r.clipped = clip;
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Results are taken before new inputs so an empty store is never popped by its own push.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $error("result item with no input item pending");
          mismatch_count++;
        end else begin
          want = expected_frames.pop_front();
          check_field("phase_a", want.phase_a, out_item.phase_a);
          check_field("phase_b", want.phase_b, out_item.phase_b);
          check_field("phase_c", want.phase_c, out_item.phase_c);
          check_field("alpha_axis", want.alpha_axis, out_item.alpha_axis);
          check_field("beta_axis", want.beta_axis, out_item.beta_axis);
          check_field("direct_axis", want.direct_axis, out_item.direct_axis);
          check_field("quadrature_axis", want.quadrature_axis, out_item.quadrature_axis);
          check_field("clipped", want.clipped, out_item.clipped);
        end
      end
      if (in_valid && in_ready) expected_frames.push_back(transform_frames(in_item));
    end
    frames_pending <= expected_frames.size();
  end

endmodule

// ----- tb/clarke_park_transform_tb.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the Clarke/Park transform, with the checker alongside.
module clarke_park_transform_tb;
  import cpt_pkg::*;

  // Operation code 3 has no frame behind it; the block must return zeros.
  localparam op_t OP_NONE = 2'd3;

  // Watchdog: cycles with no item moving on either side. The slowest legal
  // stretch is a long sender gap plus a long receiver stall plus 7 stages.
  localparam int QUIET_LIMIT = 2000;
  // Settle time after the last result.
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS = 500;

  typedef enum {RX_FREE, RX_RANDOM, RX_HEAVY} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int        mismatch_count;
  int        frames_pending;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  bit        tx_idle = 1'b1;
  rx_mode_t  rx_mode = RX_RANDOM;

  always #4 clk = ~clk;

  clarke_park_transform dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  clarke_park_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .frames_pending (frames_pending)
  );

  // Idle length: mostly zero or short, now and then a long one.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Receiver: free-running, light stalls, or heavy backpressure per phase.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (rx_mode == RX_FREE) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < ((rx_mode == RX_HEAVY) ? 50 : 20)) begin
      out_ready <= 1'b0;
      stall_left <= idle_length();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_item(op_t op, value_t a, value_t b, value_t c,
                                         logic [ANGLE_BITS-1:0] ang);
    in_item_t it;
    it.operation = op;
    it.in_first = a;
    it.in_second = b;
    it.in_third = c;
    it.angle = ang;
    return it;
  endfunction

  // Field values lean on the rails and on zero so saturation shows up often.
  function automatic value_t random_value();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return value_t'(-32768);
      1: return value_t'(32767);
      2: return value_t'(0);
      3, 4: return value_t'($urandom_range(0, 400)) - value_t'(200);
      default: return value_t'($urandom);
    endcase
  endfunction

  // Angles: mostly anywhere, some on either side of a quadrant boundary.
  function automatic logic [ANGLE_BITS-1:0] random_angle();
    logic [1:0] quad;
    quad = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: return {quad, {(ANGLE_BITS-2){1'b0}}};
      1: return {quad, {(ANGLE_BITS-2){1'b1}}};
      default: return ANGLE_BITS'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item();
    int  pick;
    op_t op;
    pick = $urandom_range(0, 99);
    if (pick < 32) op = OP_ABC;
    else if (pick < 62) op = OP_AB;
    else if (pick < 95) op = OP_DQ;
    else op = OP_NONE;
    return make_item(op, random_value(), random_value(), random_value(), random_angle());
  endfunction

  // Hold valid until the item is taken; then maybe drop it for a gap.
  // With no gap valid stays high into the next item.
  task automatic send_item(in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    gap = tx_idle ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed items: rails, every frame, quadrant edges, forced clipping,
    // ignored third input on alpha/beta and d/q, and the undefined frame.
    send_item(make_item(OP_ABC, 0, 0, 0, 16'h0000));
    send_item(make_item(OP_ABC, 32767, 32767, 32767, 16'h0000));
    send_item(make_item(OP_ABC, -32768, -32768, -32768, 16'h4000));
    send_item(make_item(OP_ABC, 32767, -32768, -32768, 16'h2000));   // alpha rails
    send_item(make_item(OP_ABC, -32768, 32767, 32767, 16'h8000));
    send_item(make_item(OP_ABC, 0, 32767, -32768, 16'hFFFF));        // beta rails
    send_item(make_item(OP_ABC, 1000, -500, -500, 16'hC000));
    send_item(make_item(OP_AB, 32767, 32767, 0, 16'h2000));          // d rails
    send_item(make_item(OP_AB, -32768, -32768, 32767, 16'hA000));
    send_item(make_item(OP_AB, 32767, 0, -32768, 16'h0000));
    send_item(make_item(OP_AB, 0, -32768, -1, 16'h4000));
    send_item(make_item(OP_AB, 12345, -23456, 32767, 16'h3FFF));
    send_item(make_item(OP_DQ, 32767, 32767, 0, 16'h2000));          // beta rails
    send_item(make_item(OP_DQ, -32768, 32767, -32768, 16'hE000));
    send_item(make_item(OP_DQ, 32767, -32768, 5, 16'hFFFF));
    send_item(make_item(OP_DQ, 0, 0, -32768, 16'h8000));
    send_item(make_item(OP_DQ, 32767, 0, 0, 16'h6000));
    send_item(make_item(OP_DQ, -1, 1, 32767, 16'hBFFF));
    send_item(make_item(OP_NONE, 32767, -32768, 32767, 16'hFFFF));
    send_item(make_item(OP_NONE, -1, -1, -1, 16'h0000));
    send_item(make_item(OP_NONE, -32768, 32767, -32768, 16'h5555));
    wait_for_drain();

    // Random phases, each with its own idling pattern on both sides.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle = 1'b1; rx_mode = RX_RANDOM; end
        1: begin tx_idle = 1'b0; rx_mode = RX_FREE;   end   // back to back
        2: begin tx_idle = 1'b1; rx_mode = RX_HEAVY;  end
        default: begin tx_idle = 1'b0; rx_mode = RX_HEAVY; end  // full pipe
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
